// ----- hdl/sfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_pkg: shared types and constants of the scan frame builder
// Job record passed from the classifier to the byte serializer, frame
// constants and the point count limit.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam int unsigned MAX_POINTS = 512;
    localparam int unsigned PTS_W      = 10;

    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_POINT  = 1'b1;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  SYNC_A    = 8'hAA;
    localparam logic [7:0]  SYNC_B    = 8'h55;
    localparam logic [7:0]  TYPE_SCAN = 8'h01;

    localparam int unsigned IN_DATA_W  = 104;
    localparam int unsigned PAYLOAD_W  = 72;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic {
        JOB_HEADER,
        JOB_POINT
    } job_kind_t;

    // header: [15:0] revolution, [31:16] saturated count
    // point:  [31:0] angle, [63:32] distance, [71:64] quality
    typedef struct packed {
        job_kind_t            kind;
        logic                 close;
        logic [PAYLOAD_W-1:0] payload;
    } job_t;

endpackage

// ----- hdl/sfb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_front: request classifier
// Accepts header and point requests, keeps frame state, saturates the count,
// drops stray points and queues jobs for the serializer.
// ----------------------------------------------------------------------------
module sfb_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sfb_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                               s_tuser,
    output logic                               push,
    output sfb_pkg::job_t                      push_job,
    input  logic                               q_full
);
    import sfb_pkg::*;

    logic [PTS_W-1:0] points_left_reg, points_left_next;
    logic             frame_open_reg, frame_open_next;
    logic [15:0]      count_in;
    logic [15:0]      count_sat;
    logic             accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign count_in = s_tdata[31:16];
    assign count_sat = (count_in > 16'(MAX_POINTS)) ? 16'(MAX_POINTS) : count_in;

    always_comb begin
        points_left_next = points_left_reg;
        frame_open_next  = frame_open_reg;
        push             = 1'b0;
        push_job.kind    = JOB_POINT;
        push_job.close   = 1'b0;
        push_job.payload = s_tdata[PAYLOAD_W+31:32];
        if (accept) begin
            if (s_tuser == CMD_HEADER) begin
                push             = 1'b1;
                push_job.kind    = JOB_HEADER;
                push_job.close   = (count_sat == 16'd0);
                push_job.payload = {40'd0, count_sat, s_tdata[15:0]};
                points_left_next = count_sat[PTS_W-1:0];
                frame_open_next  = (count_sat != 16'd0);
            end else if (frame_open_reg && points_left_reg != '0) begin
                push             = 1'b1;
                push_job.close   = (points_left_reg == PTS_W'(1));
                points_left_next = points_left_reg - PTS_W'(1);
                frame_open_next  = (points_left_reg != PTS_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_left_reg <= '0;
            frame_open_reg  <= 1'b0;
        end else begin
            points_left_reg <= points_left_next;
            frame_open_reg  <= frame_open_next;
        end
    end

endmodule

// ----- hdl/sfb_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_queue: job queue
// Small show-ahead FIFO between classifier and serializer.
// ----------------------------------------------------------------------------
module sfb_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sfb_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output sfb_pkg::job_t head_job,
    output logic          empty
);
    import sfb_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0
                                                                    : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0
                                                                    : rd_ptr_reg + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (PTR_W+1)'(1);
                2'b01:   count_reg <= count_reg - (PTR_W+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hdl/sfb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_back: byte serializer
// Walks each job one byte per cycle while the receiver is ready, keeps the running CRC-16/MODBUS and
// holds the current byte in an output register.
// ----------------------------------------------------------------------------
module sfb_back (
    input  logic          aclk,
    input  logic          aresetn,
    output logic          pop,
    input  sfb_pkg::job_t head_job,
    input  logic          empty,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast
);
    import sfb_pkg::*;

    localparam logic [3:0] HDR_LAST      = 4'd6;
    localparam logic [3:0] HDR_LAST_CRC  = 4'd8;
    localparam logic [3:0] PT_LAST       = 4'd8;
    localparam logic [3:0] PT_LAST_CRC   = 4'd10;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    job_t        job_reg, job_next;
    logic        active_reg, active_next;
    logic [3:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    logic        advance;
    logic [3:0]  last_idx;
    logic [7:0]  cur_byte;
    logic        cur_hashed;
    logic        cur_end;
    logic        job_done;

    assign advance = active_reg && (!out_valid_reg || m_tready);

    always_comb begin
        if (job_reg.kind == JOB_HEADER) begin
            last_idx = job_reg.close ? HDR_LAST_CRC : HDR_LAST;
        end else begin
            last_idx = job_reg.close ? PT_LAST_CRC : PT_LAST;
        end
    end

    always_comb begin
        cur_byte   = crc_reg[7:0];
        cur_hashed = 1'b0;
        cur_end    = 1'b0;
        if (job_reg.kind == JOB_HEADER) begin
            case (idx_reg)
                4'd0:    cur_byte = SYNC_A;
                4'd1:    cur_byte = SYNC_B;
                4'd2:    begin cur_byte = TYPE_SCAN;             cur_hashed = 1'b1; end
                4'd3:    begin cur_byte = job_reg.payload[7:0];   cur_hashed = 1'b1; end
                4'd4:    begin cur_byte = job_reg.payload[15:8];  cur_hashed = 1'b1; end
                4'd5:    begin cur_byte = job_reg.payload[23:16]; cur_hashed = 1'b1; end
                4'd6:    begin cur_byte = job_reg.payload[31:24]; cur_hashed = 1'b1; end
                4'd7:    cur_byte = crc_reg[7:0];
                default: begin cur_byte = crc_reg[15:8]; cur_end = 1'b1; end
            endcase
        end else begin
            case (idx_reg)
                4'd0:    begin cur_byte = job_reg.payload[7:0];   cur_hashed = 1'b1; end
                4'd1:    begin cur_byte = job_reg.payload[15:8];  cur_hashed = 1'b1; end
                4'd2:    begin cur_byte = job_reg.payload[23:16]; cur_hashed = 1'b1; end
                4'd3:    begin cur_byte = job_reg.payload[31:24]; cur_hashed = 1'b1; end
                4'd4:    begin cur_byte = job_reg.payload[39:32]; cur_hashed = 1'b1; end
                4'd5:    begin cur_byte = job_reg.payload[47:40]; cur_hashed = 1'b1; end
                4'd6:    begin cur_byte = job_reg.payload[55:48]; cur_hashed = 1'b1; end
                4'd7:    begin cur_byte = job_reg.payload[63:56]; cur_hashed = 1'b1; end
                4'd8:    begin cur_byte = job_reg.payload[71:64]; cur_hashed = 1'b1; end
                4'd9:    cur_byte = crc_reg[7:0];
                default: begin cur_byte = crc_reg[15:8]; cur_end = 1'b1; end
            endcase
        end
    end

    assign job_done = advance && (idx_reg == last_idx);
    // next job loads in the same cycle the current one finishes
    assign pop      = !empty && (!active_reg || job_done);

    always_comb begin
        job_next       = job_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = cur_end;
            idx_next       = idx_reg + 4'd1;
            if (job_reg.kind == JOB_HEADER && idx_reg == 4'd0) begin
                crc_next = CRC_INIT;
            end else if (cur_hashed) begin
                crc_next = crc_byte(crc_reg, cur_byte);
            end else if (cur_end) begin
                crc_next = CRC_INIT;
            end
            if (job_done) begin
                active_next = 1'b0;
            end
        end
        if (pop) begin
            job_next    = head_job;
            active_next = 1'b1;
            idx_next    = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hdl/scan_frame_builder_crc16_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_frame_builder_crc16_top: scan frame builder with CRC-16/MODBUS
// A request passes through the job queue and the serializer's job register before its first byte is on m_*.
// One output byte per cycle while m_tready is high; a point is 9 bytes (11 if last),
// a header 7 (9 with zero count), sent by the byte serializer.
// Requests queue in a 2-entry job FIFO, so intake runs ahead of the output.
// Reset: synchronous, active low; no frame open, CRC at 0xFFFF, queue empty.
// ----------------------------------------------------------------------------
module scan_frame_builder_crc16_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // revolution[15:0], point_count[31:16], angle_bits[63:32],
    // distance_bits[95:64], quality[103:96]
    input  logic [sfb_pkg::IN_DATA_W-1:0] s_tdata,
    // cmd[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // frame_byte[7:0]
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast
);
    import sfb_pkg::*;

    logic push, q_full, pop, q_empty;
    job_t push_job, head_job;

    sfb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    sfb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    sfb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- tb/tb_scan_frame_builder_crc16_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scan_frame_builder_crc16_top: self-checking bench for the scan frame builder
// Drives header and point requests with bursty timing against a stalling
// receiver. A local frame model predicts every output byte, with CRC-16/MODBUS,
// and each byte is checked in order as it leaves the block. Directed cases
// cover empty frames, ignored points, aborts and count saturation. A random
// phase of mostly complete frames with some aborts, big counts and noise follows.
// ----------------------------------------------------------------------------
module tb_scan_frame_builder_crc16_top;
    import sfb_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS = 85;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = CMD_HEADER;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;

    // frame model state
    logic [15:0]      model_crc  = CRC_INIT;
    logic [PTS_W-1:0] model_left = '0;
    logic             model_open = 1'b0;

    frame_byte_t frame_bytes_q[$];
    frame_byte_t want;

    int errors        = 0;
    int items_sent    = 0;
    int items_ignored = 0;
    int bytes_checked = 0;
    int frames_closed = 0;
    int frames_aborted = 0;
    int burst_left    = 0;
    int ready_run     = 0;
    int unsigned cycles = 0;

    scan_frame_builder_crc16_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d bytes still pending", $time, frame_bytes_q.size());
            $display("tb_scan_frame_builder_crc16_top: errors");
            $finish;
        end
    end

    // receiver: ready runs of random length, short stalls, occasional long runs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            ready_run <= 0;
        end else if (ready_run == 0) begin
            if (m_tready) begin
                m_tready  <= 1'b0;
                ready_run <= $urandom_range(0, 3);
            end else begin
                m_tready  <= 1'b1;
                ready_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 10);
            end
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_bytes_q.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = frame_bytes_q.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: frame_byte mismatch, expected %02h, actual %02h",
                             $time, want.value, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                             $time, want.last, m_tlast);
                    errors++;
                end
                bytes_checked++;
            end
        end
    end

    function automatic logic [15:0] crc16_modbus(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic emit_byte(input logic [7:0] b, input logic hashed, input logic last);
        frame_byte_t fb;
        fb.value = b;
        fb.last  = last;
        frame_bytes_q.push_back(fb);
        if (hashed) model_crc = crc16_modbus(model_crc, b);
    endtask

    task automatic close_model_frame();
        logic [15:0] c;
        c = model_crc;
        emit_byte(c[7:0], 1'b0, 1'b0);
        emit_byte(c[15:8], 1'b0, 1'b1);
        model_crc  = CRC_INIT;
        model_left = '0;
        model_open = 1'b0;
        frames_closed++;
    endtask

    // expected bytes for one accepted request; returns how many it causes
    task automatic predict_frame_bytes(input logic cmd, input logic [IN_DATA_W-1:0] d,
                                       output int produced);
        int          before_n;
        logic [15:0] cnt;
        before_n = frame_bytes_q.size();
        if (cmd == CMD_HEADER) begin
            if (model_open) frames_aborted++;
            cnt = (d[31:16] > MAX_POINTS) ? 16'(MAX_POINTS) : d[31:16];
            model_crc = CRC_INIT;
            emit_byte(SYNC_A, 1'b0, 1'b0);
            emit_byte(SYNC_B, 1'b0, 1'b0);
            emit_byte(TYPE_SCAN, 1'b1, 1'b0);
            emit_byte(d[7:0], 1'b1, 1'b0);
            emit_byte(d[15:8], 1'b1, 1'b0);
            emit_byte(cnt[7:0], 1'b1, 1'b0);
            emit_byte(cnt[15:8], 1'b1, 1'b0);
            model_left = cnt[PTS_W-1:0];
            model_open = 1'b1;
            if (model_left == 0) close_model_frame();
        end else if (model_open && model_left != 0) begin
            for (int k = 0; k < 4; k++) emit_byte(d[32 + 8*k +: 8], 1'b1, 1'b0);
            for (int k = 0; k < 4; k++) emit_byte(d[64 + 8*k +: 8], 1'b1, 1'b0);
            emit_byte(d[103:96], 1'b1, 1'b0);
            model_left = model_left - PTS_W'(1);
            if (model_left == 0) close_model_frame();
        end
        produced = frame_bytes_q.size() - before_n;
    endtask

    function automatic logic [IN_DATA_W-1:0] header_data(logic [15:0] rev, logic [15:0] cnt);
        logic [IN_DATA_W-1:0] d;
        d[15:0]   = rev;
        d[31:16]  = cnt;
        d[63:32]  = $urandom;
        d[95:64]  = $urandom;
        d[103:96] = 8'($urandom_range(0, 255));
        return d;
    endfunction

    function automatic logic [IN_DATA_W-1:0] point_data(logic [31:0] angle,
                                                        logic [31:0] dist_bits,
                                                        logic [7:0] qual);
        logic [IN_DATA_W-1:0] d;
        d[15:0]   = 16'($urandom_range(0, 65535));
        d[31:16]  = 16'($urandom_range(0, 65535));
        d[63:32]  = angle;
        d[95:64]  = dist_bits;
        d[103:96] = qual;
        return d;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_point();
        return point_data($urandom, $urandom, 8'($urandom_range(0, 255)));
    endfunction

    // called at a rising edge; returns at a rising edge
    task automatic send_request(input logic cmd, input logic [IN_DATA_W-1:0] d);
        int produced;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_frame_bytes(cmd, d, produced);
        if (produced > 0) items_sent++;
        else items_ignored++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (frame_bytes_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_idle_points();
        send_request(CMD_POINT, point_data('0, '0, '0));
        send_request(CMD_POINT, point_data('1, '1, '1));
    endtask

    task automatic test_empty_frames();
        send_request(CMD_HEADER, header_data(16'hFFFF, 16'h0000));
        send_request(CMD_HEADER, header_data(16'h0000, 16'h0000));
    endtask

    task automatic test_single_point();
        send_request(CMD_HEADER, header_data(16'h0000, 16'h0001));
        send_request(CMD_POINT, point_data('1, '1, '1));
        // frame already complete: dropped
        send_request(CMD_POINT, point_data('0, '0, '0));
    endtask

    task automatic test_header_abort();
        send_request(CMD_HEADER, header_data(16'h1234, 16'h0003));
        send_request(CMD_POINT, point_data('0, '0, '0));
        send_request(CMD_HEADER, header_data(16'hBEEF, 16'h0002));
        send_request(CMD_POINT, random_point());
        send_request(CMD_POINT, random_point());
        wait_drained();
    endtask

    task automatic test_count_saturation();
        send_request(CMD_HEADER, header_data(16'hA5A5, 16'hFFFF));
        send_request(CMD_POINT, random_point());
        send_request(CMD_HEADER, header_data(16'h5A5A, 16'(MAX_POINTS + 1)));
        send_request(CMD_POINT, random_point());
        send_request(CMD_HEADER, header_data(16'h0001, 16'(MAX_POINTS)));
        send_request(CMD_HEADER, header_data(16'h0002, 16'(MAX_POINTS - 1)));
        send_request(CMD_HEADER, header_data(16'h0003, 16'h0002));
        send_request(CMD_POINT, random_point());
        send_request(CMD_POINT, random_point());
    endtask

    // mostly complete frames with random content; some aborts, big counts and noise
    task automatic test_random_frames(input int target);
        int npts;
        int roll;
        logic [15:0] cnt;
        target = target + items_sent;
        while (items_sent < target) begin
            roll = $urandom_range(0, 19);
            if (roll == 0 && !model_open) begin
                send_request(CMD_POINT, random_point());
            end
            if (roll == 1) cnt = 16'($urandom_range(0, 65535));
            else cnt = 16'($urandom_range(0, 6));
            send_request(CMD_HEADER, header_data(16'($urandom_range(0, 65535)), cnt));
            npts = (cnt > 6) ? $urandom_range(0, 4) : cnt;
            for (int k = 0; k < npts; k++) begin
                if ($urandom_range(0, 15) == 0) break;
                send_request(CMD_POINT, random_point());
            end
            if (roll == 2 && !model_open) begin
                send_request(CMD_POINT, random_point());
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_points();
        test_empty_frames();
        test_single_point();
        test_header_abort();
        test_count_saturation();
        test_random_frames(RANDOM_ITEMS);
        wait_drained();
        $display("covered %0d requests with output and %0d dropped points, %0d bytes checked",
                 items_sent, items_ignored, bytes_checked);
        $display("frames closed with CRC: %0d, frames cut short by a new header: %0d",
                 frames_closed, frames_aborted);
        if (errors == 0) begin
            $display("tb_scan_frame_builder_crc16_top: clean");
        end else begin
            $display("tb_scan_frame_builder_crc16_top: errors");
        end
        $finish;
    end

endmodule

// ----- scan_frame_builder_crc16_top.f -----
hdl/sfb_pkg.sv
hdl/sfb_front.sv
hdl/sfb_queue.sv
hdl/sfb_back.sv
hdl/scan_frame_builder_crc16_top.sv
tb/tb_scan_frame_builder_crc16_top.sv
